// ----- design/tsw_pkg.sv -----
package tsw_pkg;

	// geometry limits
	localparam int MAX_WIDTH  = 1024;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int WID_W      = COL_W + 1;
	localparam int CFG_WID_W  = 11;
	localparam int HEIGHT_W   = 16;
	localparam int ROW_W      = HEIGHT_W + 1;

	// configuration port
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PHASE  = 2'd0,
		CFG_WIDTH  = 2'd1,
		CFG_HEIGHT = 2'd2
	} cfg_reg_t;

	// decoupling queue
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// effective configuration seen by the datapath
	typedef struct packed {
		logic               phase;
		logic [WID_W-1:0]   width;
		logic [HEIGHT_W-1:0] height;
		logic               restart;
	} cfg_t;

	// one window to be judged: columns are {bottom, middle, top}
	typedef struct packed {
		logic [2:0] left;
		logic [2:0] centre;
		logic [2:0] right;
		logic       last;
	} entry_t;

endpackage

// ----- design/tsw_pixel_if.sv -----
interface tsw_pixel_if;
	logic valid;
	logic ready;
	logic pixel_in;
	logic flush;

	modport source (output valid, output pixel_in, output flush, input ready);
	modport sink (input valid, input pixel_in, input flush, output ready);
endinterface

// ----- design/tsw_result_if.sv -----
interface tsw_result_if;
	logic valid;
	logic ready;
	logic pixel_out;
	logic removed;
	logic frame_last;
	logic frame_changed;

	modport source (output valid, output pixel_out, output removed, output frame_last,
		output frame_changed, input ready);
	modport sink (input valid, input pixel_out, input removed, input frame_last,
		input frame_changed, output ready);
endinterface

// ----- design/tsw_front.sv -----
module tsw_front import tsw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	tsw_pixel_if.sink         pixels,
	input  cfg_t              cfg,
	input  logic [QCNT_W-1:0] q_count,
	output logic              push,
	output entry_t            push_data
);

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [8:0]       win_q;

	logic             valid_s1;
	logic [COL_W-1:0] col_s1;
	logic             px_s1;
	logic             first_s1;
	logic             emit_s1;
	logic             last_s1;
	logic             rge1_s1;
	logic             rge2_s1;
	logic             mid_rd_s1;
	logic             up_rd_s1;
	logic             fwd_s1;
	logic             fwd_data_s1;

	logic mid_mem [MAX_WIDTH];
	logic up_mem [MAX_WIDTH];

	logic             accept;
	logic [ROW_W-1:0] h_ext;
	logic [ROW_W-1:0] h_plus1;
	logic             px0;
	logic             first_col;
	logic             emit0;
	logic             last0;
	logic [WID_W-1:0] col_inc;
	logic             wrap;
	logic [QCNT_W:0]  occupancy;

	logic       up_bit;
	logic       mid_bit;
	logic [2:0] col_bits;
	logic [8:0] shifted;

	// space is reserved for the item in stage 1
	assign occupancy    = (QCNT_W+1)'(q_count) + (QCNT_W+1)'(valid_s1);
	assign pixels.ready = occupancy < (QCNT_W+1)'(QDEPTH);
	assign accept       = pixels.valid && pixels.ready;

	assign h_ext     = {1'b0, cfg.height};
	assign h_plus1   = h_ext + 1'b1;
	assign px0       = !pixels.flush && (row_q < h_ext) && pixels.pixel_in;
	assign first_col = col_q == '0;
	assign last0     = row_q == h_plus1;
	assign emit0     = first_col ? ((row_q >= ROW_W'(2)) && (row_q <= h_plus1))
	                             : ((row_q != '0) && (row_q <= h_ext));
	assign col_inc   = {1'b0, col_q} + 1'b1;
	assign wrap      = col_inc >= cfg.width;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg.restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (first_col && last0) begin
				col_q <= '0;
				row_q <= '0;
			end else if (wrap) begin
				col_q <= '0;
				row_q <= row_q + 1'b1;
			end else begin
				col_q <= col_inc[COL_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	// row stores, read-before-write; upper store written in the cycle after the read
	always_ff @(posedge clk) begin
		if (accept) begin
			mid_rd_s1      <= mid_mem[col_q];
			up_rd_s1       <= up_mem[col_q];
			mid_mem[col_q] <= px0;
			fwd_s1         <= valid_s1 && (col_s1 == col_q);
			fwd_data_s1    <= mid_rd_s1;
			col_s1         <= col_q;
			px_s1          <= px0;
			first_s1       <= first_col;
			emit_s1        <= emit0;
			last_s1        <= first_col && last0;
			rge1_s1        <= row_q != '0;
			rge2_s1        <= row_q >= ROW_W'(2);
		end
		if (valid_s1) begin
			up_mem[col_s1] <= mid_rd_s1;
		end
	end

	assign up_bit   = rge2_s1 && (fwd_s1 ? fwd_data_s1 : up_rd_s1);
	assign mid_bit  = rge1_s1 && mid_rd_s1;
	assign col_bits = {px_s1, mid_bit, up_bit};
	assign shifted  = {col_bits, win_q[8:3]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (cfg.restart) begin
			win_q <= '0;
		end else if (valid_s1) begin
			if (first_s1) begin
				win_q <= last_s1 ? 9'd0 : {col_bits, 6'd0};
			end else begin
				win_q <= shifted;
			end
		end
	end

	assign push = valid_s1 && emit_s1;

	always_comb begin
		push_data.last = last_s1;
		if (first_s1) begin
			push_data.left   = win_q[5:3];
			push_data.centre = win_q[8:6];
			push_data.right  = 3'd0;
		end else begin
			push_data.left   = shifted[2:0];
			push_data.centre = shifted[5:3];
			push_data.right  = shifted[8:6];
		end
	end

endmodule

// ----- design/tsw_queue.sv -----
module tsw_queue import tsw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  entry_t            push_data,
	input  logic              pop,
	output entry_t            head,
	output logic [QCNT_W-1:0] count
);

	entry_t            slots_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head  = slots_q[rd_ptr_q];
	assign count = count_q;

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && (count_q == QCNT_W'(QDEPTH))))
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("pop from empty queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("queue count out of range");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not advance on push");
`endif

endmodule

// ----- design/tsw_back.sv -----
module tsw_back import tsw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  entry_t            head,
	input  logic [QCNT_W-1:0] q_count,
	output logic              pop,
	tsw_result_if.source      results
);

	logic valid_q;
	logic pixel_out_q;
	logic removed_q;
	logic frame_last_q;
	logic frame_changed_q;
	logic any_q;

	logic [7:0] nb;
	logic [7:0] nb_rot;
	logic [3:0] sum;
	logic [3:0] changes;
	logic       corner;
	logic       rem;
	logic       any_next;

	// neighbours clockwise from north
	assign nb = {head.left[0], head.left[1], head.left[2], head.centre[2],
	             head.right[2], head.right[1], head.right[0], head.centre[0]};
	assign nb_rot  = {nb[0], nb[7:1]};
	assign sum     = 4'($countones(nb));
	assign changes = 4'($countones(nb ^ nb_rot));

	// nb[0] north, nb[2] east, nb[4] south, nb[6] west
	assign corner = cfg.phase ? (!nb[2] || !nb[4] || (!nb[0] && !nb[6]))
	                          : (!nb[0] || !nb[6] || (!nb[2] && !nb[4]));
	assign rem = head.centre[1] && (sum >= 4'd2) && (sum <= 4'd6) &&
	             (changes == 4'd2) && corner;
	assign any_next = any_q || rem;

	assign pop = (q_count != '0) && (!valid_q || results.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			any_q   <= 1'b0;
		end else begin
			if (pop) begin
				valid_q <= 1'b1;
			end else if (results.ready) begin
				valid_q <= 1'b0;
			end
			if (cfg.restart) begin
				any_q <= 1'b0;
			end else if (pop) begin
				any_q <= head.last ? 1'b0 : any_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			pixel_out_q     <= head.centre[1] && !rem;
			removed_q       <= rem;
			frame_last_q    <= head.last;
			frame_changed_q <= head.last && any_next;
		end
	end

	assign results.valid         = valid_q;
	assign results.pixel_out     = pixel_out_q;
	assign results.removed       = removed_q;
	assign results.frame_last    = frame_last_q;
	assign results.frame_changed = frame_changed_q;

endmodule

// ----- design/thinning_subiteration_window.sv -----
// one zhang-suen thinning sub-iteration over a raster-order binary image
// pixels: one transaction per pixel, pixel_in plus a flush mark; send
// image_width + 1 flush transactions after each frame to drain the window
// results: zero or one transaction per pixel transaction; pixel_out, removed,
// and on the frame's final pixel frame_last with frame_changed
// a result corresponds to the pixel one row and one column behind the input;
// it passes stage 1, the queue and the output register after the pixel
// transaction that completes its window; one pixel is accepted every cycle
// while results drain, as each row store takes one read and one write a cycle
// cfg_we/cfg_index/cfg_data writes phase, image_width or image_height; a
// geometry write restarts the frame; write only while the block is idle
// reset clears counters, window, queue and output valid; row stores are not
// cleared, the row count masks rows above the frame
// a stalled receiver holds the output register, the queue fills, and pixels
// back-pressures once queued windows plus the stage feeding them reach QDEPTH
module thinning_subiteration_window import tsw_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	tsw_pixel_if.sink             pixels,
	tsw_result_if.source          results,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// configuration registers
	logic                 phase_q;
	logic [CFG_WID_W-1:0] width_q;
	logic [HEIGHT_W-1:0]  height_q;

	cfg_t              cfg;
	logic              push;
	entry_t            push_data;
	logic              pop;
	entry_t            head;
	logic [QCNT_W-1:0] q_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= 1'b0;
			width_q  <= CFG_WID_W'(1024);
			height_q <= HEIGHT_W'(1024);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PHASE:  phase_q  <= cfg_data[0];
				CFG_WIDTH:  width_q  <= cfg_data[CFG_WID_W-1:0];
				CFG_HEIGHT: height_q <= cfg_data[HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp geometry: width to 1..MAX_WIDTH, height zero acts as one
	always_comb begin
		cfg.phase = phase_q;
		if (width_q == '0) begin
			cfg.width = WID_W'(1);
		end else if (int'(width_q) > MAX_WIDTH) begin
			cfg.width = WID_W'(MAX_WIDTH);
		end else begin
			cfg.width = WID_W'(width_q);
		end
		cfg.height  = (height_q == '0) ? HEIGHT_W'(1) : height_q;
		// geometry write aborts the frame in progress
		cfg.restart = cfg_we && (cfg_index inside {CFG_WIDTH, CFG_HEIGHT});
	end

	// front: counters, row stores and window, one pixel a cycle unless back-pressured
	tsw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixels    (pixels),
		.cfg       (cfg),
		.q_count   (q_count),
		.push      (push),
		.push_data (push_data)
	);

	// short queue of windows between front and back
	tsw_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.count     (q_count)
	);

	// back: thinning tests, frame-changed tracking, output register
	tsw_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.head    (head),
		.q_count (q_count),
		.pop     (pop),
		.results (results)
	);

endmodule
